// ----- hw/rtl/rcp_pkg.sv -----
// ---------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants of the rotator command parser: field widths,
// ASCII codes, result kinds, command codes and the queue entry layout.
// ---------------------------------------------------------------------------
package rcp_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

    localparam int BYTE_W   = 8;
    localparam int AZ_IN_W  = 13;
    localparam int EL_IN_W  = 11;
    localparam int KIND_W   = 3;
    localparam int TARGET_W = 14;
    localparam int DEG_W    = 10;
    localparam int NUM_W    = 10;

    // x / 10 for x below 2**13 as (x * 52429) >> 19
    localparam int DIV10_MUL_W = 16;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
    localparam int DIV10_SHIFT = 19;
    localparam int DIV10_PROD_W = AZ_IN_W + DIV10_MUL_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // reply byte sequencing
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_EL_BASE = 4'd7;
    localparam logic [STEP_W-1:0] STEP_AZ_END  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LAST    = 4'd13;

    // result kinds on the output channel
    localparam logic [KIND_W-1:0] KIND_REPLY    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STOP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_AZ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_BOTH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

    // ascii
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_2     = 8'h32;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3d;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_L     = 8'h4c;
    localparam logic [BYTE_W-1:0] CH_M     = 8'h4d;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_W     = 8'h57;
    localparam logic [BYTE_W-1:0] CH_Z     = 8'h5a;

    typedef enum logic [2:0] {
        CMD_STOP,
        CMD_REPLY_AZ,
        CMD_REPLY_EL,
        CMD_REPLY_BOTH,
        CMD_SET_AZ,
        CMD_SET_BOTH,
        CMD_NONE
    } t_cmd_kind;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_SKIP_A,
        PH_DIGIT_A,
        PH_SKIP_B,
        PH_DIGIT_B
    } t_parse_phase;

    // val_a/val_b: degrees for replies, tenths for set commands
    typedef struct packed {
        t_cmd_kind             kind;
        logic [TARGET_W-1:0]   val_a;
        logic [TARGET_W-1:0]   val_b;
    } t_cmd;

endpackage

// ----- hw/rtl/rcp_in_if.sv -----
// ---------------------------------------------------------------------------
// rcp_in_if
// Input channel: one command byte per beat with position inputs.
// ---------------------------------------------------------------------------
interface rcp_in_if;
    logic                         valid;
    logic                         ready;
    logic [rcp_pkg::BYTE_W-1:0]   rx_byte;
    logic                         end_of_message;
    logic [rcp_pkg::AZ_IN_W-1:0]  current_az_ddeg;
    logic [rcp_pkg::EL_IN_W-1:0]  current_el_ddeg;

    modport source (
        output valid, rx_byte, end_of_message, current_az_ddeg, current_el_ddeg,
        input  ready
    );
    modport sink (
        input  valid, rx_byte, end_of_message, current_az_ddeg, current_el_ddeg,
        output ready
    );
endinterface

// ----- hw/rtl/rcp_out_if.sv -----
// ---------------------------------------------------------------------------
// rcp_out_if
// Output channel: one result per beat.
// ---------------------------------------------------------------------------
interface rcp_out_if;
    logic                          valid;
    logic                          ready;
    logic [rcp_pkg::KIND_W-1:0]    out_kind;
    logic [rcp_pkg::BYTE_W-1:0]    reply_byte;
    logic [rcp_pkg::TARGET_W-1:0]  target_az_ddeg;
    logic [rcp_pkg::TARGET_W-1:0]  target_el_ddeg;
    logic                          out_last;

    modport source (
        output valid, out_kind, reply_byte, target_az_ddeg, target_el_ddeg, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_kind, reply_byte, target_az_ddeg, target_el_ddeg, out_last,
        output ready
    );
endinterface

// ----- hw/rtl/rcp_front.sv -----
// ---------------------------------------------------------------------------
// rcp_front
// Takes message bytes, keeps the command prefix, parses the decimal
// arguments on the fly and classifies the message on its final byte.
// ---------------------------------------------------------------------------
module rcp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rcp_in_if.sink         i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output rcp_pkg::t_cmd  o_cmd
);
    import rcp_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count, u_count;
    logic [BYTE_W-1:0]  r_b0, r_b1, r_b2, n_b0, n_b1, n_b2;
    t_parse_phase       r_phase, n_phase, u_phase;
    logic [NUM_W-1:0]   r_num_a, r_num_b, u_num_a, u_num_b;
    logic [1:0]         r_ndig, u_ndig;

    logic              acc;
    logic              keep;
    logic [BYTE_W-1:0] b;
    logic              is_dig;
    logic              is_ws;
    logic [3:0]        dval;
    logic [NUM_W-1:0]  acc_a, acc_b;

    logic [DIV10_PROD_W-1:0] az_prod, el_prod;

    function automatic logic [NUM_W-1:0] mul10_add(input logic [NUM_W-1:0] v,
                                                   input logic [3:0] d);
        logic [TARGET_W-1:0] w;
        w = (TARGET_W'(v) << 3) + (TARGET_W'(v) << 1) + TARGET_W'(d);
        return w[NUM_W-1:0];
    endfunction

    assign i_in.ready = ~i_q_full;
    assign acc    = i_in.valid & ~i_q_full;
    assign b      = i_in.rx_byte;
    assign keep   = acc && (r_count < COUNT_W'(BUFFER_BYTES));
    assign is_dig = b inside {[CH_0:CH_9]};
    assign is_ws  = b inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign dval   = b[3:0];
    assign acc_a  = mul10_add(r_num_a, dval);
    assign acc_b  = mul10_add(r_num_b, dval);

    // kept prefix bytes and count, after this beat
    always_comb begin
        u_count = r_count;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_b2    = r_b2;
        if (keep) begin
            u_count = r_count + COUNT_W'(1);
            if (r_count == COUNT_W'(0)) n_b0 = b;
            if (r_count == COUNT_W'(1)) n_b1 = b;
            if (r_count == COUNT_W'(2)) n_b2 = b;
        end
    end

    // parser next state
    always_comb begin
        u_phase = r_phase;
        if (keep) begin
            if (r_count == COUNT_W'(0)) begin
                u_phase = (b == CH_M || b == CH_W) ? PH_SKIP_A : PH_DONE;
            end else begin
                case (r_phase)
                    PH_SKIP_A: begin
                        if (is_dig)      u_phase = PH_DIGIT_A;
                        else if (!is_ws) u_phase = PH_DONE;
                    end
                    PH_DIGIT_A: begin
                        if (is_dig) begin
                            if (r_ndig == 2'd2) u_phase = PH_SKIP_B;
                        end else if (is_ws) begin
                            u_phase = PH_SKIP_B;
                        end else begin
                            u_phase = PH_DONE;
                        end
                    end
                    PH_SKIP_B: begin
                        if (is_dig)      u_phase = PH_DIGIT_B;
                        else if (!is_ws) u_phase = PH_DONE;
                    end
                    PH_DIGIT_B: begin
                        if (!is_dig || r_ndig == 2'd2) u_phase = PH_DONE;
                    end
                    default: u_phase = PH_DONE;
                endcase
            end
        end
    end

    // parser data path
    always_comb begin
        u_num_a = r_num_a;
        u_num_b = r_num_b;
        u_ndig  = r_ndig;
        if (keep) begin
            if (r_count == COUNT_W'(0)) begin
                u_num_a = '0;
                u_num_b = '0;
                u_ndig  = '0;
            end else begin
                case (r_phase)
                    PH_SKIP_A: begin
                        if (is_dig) begin
                            u_num_a = NUM_W'(dval);
                            u_ndig  = 2'd1;
                        end
                    end
                    PH_DIGIT_A: begin
                        if (is_dig) begin
                            u_num_a = acc_a;
                            u_ndig  = r_ndig + 2'd1;
                        end
                    end
                    PH_SKIP_B: begin
                        if (is_dig) begin
                            u_num_b = NUM_W'(dval);
                            u_ndig  = 2'd1;
                        end
                    end
                    PH_DIGIT_B: begin
                        if (is_dig && r_ndig != 2'd3) begin
                            u_num_b = acc_b;
                            u_ndig  = r_ndig + 2'd1;
                        end
                    end
                    default: begin
                        u_ndig = r_ndig;
                    end
                endcase
            end
        end
    end

    // count restarts after the final byte
    always_comb begin
        n_count = u_count;
        n_phase = u_phase;
        if (acc && i_in.end_of_message) begin
            n_count = '0;
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= PH_DONE;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0    <= n_b0;
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_num_a <= u_num_a;
        r_num_b <= u_num_b;
        r_ndig  <= u_ndig;
    end

    // positions in whole degrees
    assign az_prod = DIV10_PROD_W'(i_in.current_az_ddeg) * DIV10_PROD_W'(DIV10_MUL);
    assign el_prod = DIV10_PROD_W'(i_in.current_el_ddeg) * DIV10_PROD_W'(DIV10_MUL);

    // classify on the final byte, first match wins
    always_comb begin
        o_cmd.kind  = CMD_NONE;
        o_cmd.val_a = TARGET_W'(az_prod[DIV10_SHIFT +: DEG_W]);
        o_cmd.val_b = TARGET_W'(el_prod[DIV10_SHIFT +: DEG_W]);
        if (u_count >= COUNT_W'(2) && n_b0 == CH_S && n_b1 == CH_CR) begin
            o_cmd.kind = CMD_STOP;
        end else if (u_count >= COUNT_W'(2) && n_b0 == CH_C && n_b1 == CH_CR) begin
            o_cmd.kind = CMD_REPLY_AZ;
        end else if (u_count >= COUNT_W'(2) && n_b0 == CH_B && n_b1 == CH_CR) begin
            o_cmd.kind = CMD_REPLY_EL;
        end else if (u_count >= COUNT_W'(3) && n_b0 == CH_C && n_b1 == CH_2
                     && n_b2 == CH_CR) begin
            o_cmd.kind = CMD_REPLY_BOTH;
        end else if (u_count >= COUNT_W'(5) && n_b0 == CH_M) begin
            o_cmd.kind  = CMD_SET_AZ;
            o_cmd.val_a = (TARGET_W'(u_num_a) << 3) + (TARGET_W'(u_num_a) << 1);
            o_cmd.val_b = '0;
        end else if (u_count >= COUNT_W'(9) && n_b0 == CH_W) begin
            o_cmd.kind  = CMD_SET_BOTH;
            o_cmd.val_a = (TARGET_W'(u_num_a) << 3) + (TARGET_W'(u_num_a) << 1);
            o_cmd.val_b = (TARGET_W'(u_num_b) << 3) + (TARGET_W'(u_num_b) << 1);
        end
    end

    assign o_push = acc & i_in.end_of_message;

endmodule

// ----- hw/rtl/rcp_queue.sv -----
// ---------------------------------------------------------------------------
// rcp_queue
// Short command queue between the parser and the reply sequencer.
// ---------------------------------------------------------------------------
module rcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcp_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rcp_pkg::t_cmd  o_cmd
);
    import rcp_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop)      n_cnt = r_cnt + QCNT_W'(1);
        else if (!do_push && do_pop) n_cnt = r_cnt - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// ----- hw/rtl/rcp_back.sv -----
// ---------------------------------------------------------------------------
// rcp_back
// Carries out queued commands: spells query replies one byte per beat,
// or gives the single stop, set or no-action result.
// ---------------------------------------------------------------------------
module rcp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  rcp_pkg::t_cmd  i_q_cmd,
    output logic           o_q_pop,
    rcp_out_if.source      o_out
);
    import rcp_pkg::*;

    logic                r_out_valid;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [TARGET_W-1:0] r_az, r_el, n_az, n_el;
    logic                r_last, n_last;
    logic [STEP_W-1:0]   r_step;

    logic              adv;
    logic [STEP_W-1:0] eff;
    logic [DEG_W-1:0]  deg;
    logic [11:0]       bcd;

    // 3 bcd digits of a value below 1000 by compare and subtract
    function automatic logic [11:0] to_bcd(input logic [DEG_W-1:0] v);
        logic [DEG_W-1:0] r;
        logic [3:0]       h, t;
        r = v;
        h = '0;
        t = '0;
        for (int i = 3; i >= 0; i--) begin
            if (r >= (DEG_W'(100) << i)) begin
                r    = r - (DEG_W'(100) << i);
                h[i] = 1'b1;
            end
        end
        for (int i = 3; i >= 0; i--) begin
            if (r >= (DEG_W'(10) << i)) begin
                r    = r - (DEG_W'(10) << i);
                t[i] = 1'b1;
            end
        end
        return {h, t, r[3:0]};
    endfunction

    assign adv      = ~r_out_valid | o_out.ready;
    // an elevation-only reply runs the second half of the combined sequence
    assign eff = r_step + ((i_q_cmd.kind == CMD_REPLY_EL) ? STEP_EL_BASE : STEP_W'(0));
    assign deg = (eff < STEP_EL_BASE) ? i_q_cmd.val_a[DEG_W-1:0] : i_q_cmd.val_b[DEG_W-1:0];
    assign bcd = to_bcd(deg);

    always_comb begin
        n_kind = KIND_NONE;
        n_byte = '0;
        n_az   = '0;
        n_el   = '0;
        n_last = 1'b1;
        case (i_q_cmd.kind)
            CMD_STOP:     n_kind = KIND_STOP;
            CMD_SET_AZ: begin
                n_kind = KIND_SET_AZ;
                n_az   = i_q_cmd.val_a;
            end
            CMD_SET_BOTH: begin
                n_kind = KIND_SET_BOTH;
                n_az   = i_q_cmd.val_a;
                n_el   = i_q_cmd.val_b;
            end
            CMD_REPLY_AZ, CMD_REPLY_EL, CMD_REPLY_BOTH: begin
                n_kind = KIND_REPLY;
                n_last = (eff == STEP_LAST)
                         || (i_q_cmd.kind == CMD_REPLY_AZ && eff == STEP_AZ_END);
                case (eff)
                    4'd0:    n_byte = CH_A;
                    4'd1:    n_byte = CH_Z;
                    4'd2:    n_byte = CH_EQ;
                    4'd3:    n_byte = CH_0 | {4'h0, bcd[11:8]};
                    4'd4:    n_byte = CH_0 | {4'h0, bcd[7:4]};
                    4'd5:    n_byte = CH_0 | {4'h0, bcd[3:0]};
                    4'd6:    n_byte = (i_q_cmd.kind == CMD_REPLY_AZ) ? CH_CR : CH_SPACE;
                    4'd7:    n_byte = CH_E;
                    4'd8:    n_byte = CH_L;
                    4'd9:    n_byte = CH_EQ;
                    4'd10:   n_byte = CH_0 | {4'h0, bcd[11:8]};
                    4'd11:   n_byte = CH_0 | {4'h0, bcd[7:4]};
                    4'd12:   n_byte = CH_0 | {4'h0, bcd[3:0]};
                    default: n_byte = CH_CR;
                endcase
            end
            default:      n_kind = KIND_NONE;
        endcase
    end

    assign o_q_pop = adv & i_q_valid & n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else if (adv) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_step <= n_last ? STEP_W'(0) : r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_q_valid) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_az   <= n_az;
            r_el   <= n_el;
            r_last <= n_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_kind       = r_kind;
    assign o_out.reply_byte     = r_byte;
    assign o_out.target_az_ddeg = r_az;
    assign o_out.target_el_ddeg = r_el;
    assign o_out.out_last       = r_last;

endmodule

// ----- hw/rtl/rotator_command_parser_core.sv -----
// ---------------------------------------------------------------------------
// rotator_command_parser_core
// GS-232 style command parser for an antenna rotator controller.
// ---------------------------------------------------------------------------
// Command bytes are taken one per cycle. The parser keeps the first bytes
// of each message and reads the decimal arguments as they stream in, so a
// message is classified on its final beat and handed to a four-entry
// command queue. The reply sequencer drains that queue at one result per
// cycle while the output is ready, through its output register: a query
// gives 7 (C, B) or 14 (C2) reply beats, every other message exactly one
// result. The input stalls only while the command queue is full, which
// happens when replies pile up faster than the output side takes them.
module rotator_command_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcp_in_if.sink     i_in,
    rcp_out_if.source  o_out
);
    import rcp_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    rcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    rcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    rcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ----- bench/tb_rotator_command_parser_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rotator_command_parser_core
// Self-checking bench for the rotator command parser. Command messages are
// streamed in byte by byte while a built-in parser predicts every reply
// beat, stop, move request and no-action result. Each output beat is
// compared field by field with the oldest prediction. Both channels idle
// at random, the output is held off long enough to back up the input, and
// the run covers well-formed, broken, overlong and noise messages.
// ---------------------------------------------------------------------------
module tb_rotator_command_parser_core;
    import rcp_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 32;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   ch;
        logic [TARGET_W-1:0] az;
        logic [TARGET_W-1:0] el;
        logic                last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rcp_in_if  cmd_if ();
    rcp_out_if res_if ();

    rotator_command_parser_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parser shadow state
    logic [BYTE_W-1:0] msg_store [BUFFER_BYTES];
    int                kept_bytes;
    t_result           parsed_results [$];
    logic [BYTE_W-1:0] msg_buf [$];

    int  beats_sent;
    int  mismatch_count;
    bit  idle_on;
    int  hold_request;
    int  hold_left;
    int  quiet_cycles;

    function automatic bit is_blank(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // skip blanks, then take up to three digits; returns the digit count
    function automatic int read_number(inout int pos, input int len, output int val);
        int ndig;
        ndig = 0;
        val  = 0;
        while (pos < len && is_blank(msg_store[pos]))
            pos++;
        while (ndig < 3 && pos < len && msg_store[pos] >= CH_0 && msg_store[pos] <= CH_9) begin
            val = val * 10 + int'(msg_store[pos] - CH_0);
            pos++;
            ndig++;
        end
        return ndig;
    endfunction

    function automatic logic [BYTE_W-1:0] digit_char(input int d);
        return BYTE_W'(int'(CH_0) + d);
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    task automatic add_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] ch,
                              input int az, input int el, input logic last);
        t_result r;
        r.kind = kind;
        r.ch   = ch;
        r.az   = az[TARGET_W-1:0];
        r.el   = el[TARGET_W-1:0];
        r.last = last;
        parsed_results.push_back(r);
    endtask

    task automatic add_reply_char(input logic [BYTE_W-1:0] ch);
        add_result(KIND_REPLY, ch, 0, 0, 1'b0);
    endtask

    // whole degrees, three digits with leading zeros
    task automatic add_degrees(input int ddeg);
        int d;
        d = (ddeg / 10) % 1000;
        add_reply_char(digit_char(d / 100));
        add_reply_char(digit_char((d / 10) % 10));
        add_reply_char(digit_char(d % 10));
    endtask

    task automatic add_az_field(input int az);
        add_reply_char(CH_A);
        add_reply_char(CH_Z);
        add_reply_char(CH_EQ);
        add_degrees(az);
    endtask

    task automatic add_el_field(input int el);
        add_reply_char(CH_E);
        add_reply_char(CH_L);
        add_reply_char(CH_EQ);
        add_degrees(el);
    endtask

    task automatic parse_beat(input logic [BYTE_W-1:0] b, input logic eom,
                              input logic [AZ_IN_W-1:0] az, input logic [EL_IN_W-1:0] el);
        int len;
        int pos;
        int a;
        int e;
        if (kept_bytes < BUFFER_BYTES) begin
            msg_store[kept_bytes] = b;
            kept_bytes++;
        end
        if (!eom)
            return;
        len        = kept_bytes;
        kept_bytes = 0;
        a          = 0;
        e          = 0;
        if (len >= 2 && msg_store[0] == CH_S && msg_store[1] == CH_CR) begin
            add_result(KIND_STOP, '0, 0, 0, 1'b1);
        end else if (len >= 2 && msg_store[0] == CH_C && msg_store[1] == CH_CR) begin
            add_az_field(int'(az));
            add_result(KIND_REPLY, CH_CR, 0, 0, 1'b1);
        end else if (len >= 2 && msg_store[0] == CH_B && msg_store[1] == CH_CR) begin
            add_el_field(int'(el));
            add_result(KIND_REPLY, CH_CR, 0, 0, 1'b1);
        end else if (len >= 3 && msg_store[0] == CH_C && msg_store[1] == CH_2
                     && msg_store[2] == CH_CR) begin
            add_az_field(int'(az));
            add_reply_char(CH_SPACE);
            add_el_field(int'(el));
            add_result(KIND_REPLY, CH_CR, 0, 0, 1'b1);
        end else if (len >= 5 && msg_store[0] == CH_M) begin
            pos = 1;
            void'(read_number(pos, len, a));
            add_result(KIND_SET_AZ, '0, a * 10, 0, 1'b1);
        end else if (len >= 9 && msg_store[0] == CH_W) begin
            pos = 1;
            // elevation only read when the azimuth had digits
            if (read_number(pos, len, a) > 0)
                void'(read_number(pos, len, e));
            add_result(KIND_SET_BOTH, '0, a * 10, e * 10, 1'b1);
        end else begin
            add_result(KIND_NONE, '0, 0, 0, 1'b1);
        end
    endtask

    function automatic logic [AZ_IN_W-1:0] random_az();
        return AZ_IN_W'(($urandom_range(7) == 0) ? $urandom_range(8191)
                                                 : $urandom_range(4500));
    endfunction

    function automatic logic [EL_IN_W-1:0] random_el();
        return EL_IN_W'(($urandom_range(7) == 0) ? $urandom_range(2047)
                                                 : $urandom_range(1800));
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic eom,
                             input logic [AZ_IN_W-1:0] az, input logic [EL_IN_W-1:0] el);
        if (idle_on && $urandom_range(99) < 10) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cmd_if.valid           <= 1'b1;
        cmd_if.rx_byte         <= b;
        cmd_if.end_of_message  <= eom;
        cmd_if.current_az_ddeg <= az;
        cmd_if.current_el_ddeg <= el;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        parse_beat(b, eom, az, el);
        beats_sent++;
    endtask

    // positions only matter on the final beat
    task automatic send_message(input logic [AZ_IN_W-1:0] az, input logic [EL_IN_W-1:0] el);
        for (int i = 0; i < msg_buf.size(); i++) begin
            if (i == msg_buf.size() - 1)
                send_beat(msg_buf[i], 1'b1, az, el);
            else
                send_beat(msg_buf[i], 1'b0, random_az(), random_el());
        end
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (parsed_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_blank();
        msg_buf.push_back($urandom_range(1) ? CH_SPACE
                                            : BYTE_W'(int'(CH_TAB) + $urandom_range(4)));
    endtask

    task automatic push_number_field();
        repeat ($urandom_range(0, 2)) push_blank();
        if ($urandom_range(9) == 0)
            msg_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(0, 4)) msg_buf.push_back(digit_char($urandom_range(9)));
    endtask

    task automatic build_random_message();
        int pick;
        pick = $urandom_range(99);
        msg_buf.delete();
        if (pick < 10) begin
            msg_buf.push_back(CH_S);
            msg_buf.push_back(CH_CR);
        end else if (pick < 25) begin
            case ($urandom_range(2))
                0: msg_buf.push_back(CH_C);
                1: msg_buf.push_back(CH_B);
                default: begin
                    msg_buf.push_back(CH_C);
                    msg_buf.push_back(CH_2);
                end
            endcase
            msg_buf.push_back(CH_CR);
        end else if (pick < 48) begin
            msg_buf.push_back(CH_M);
            push_number_field();
            msg_buf.push_back(CH_CR);
        end else if (pick < 75) begin
            msg_buf.push_back(CH_W);
            push_number_field();
            if ($urandom_range(5) == 0)
                msg_buf.push_back(CH_COMMA);
            push_number_field();
            msg_buf.push_back(CH_CR);
        end else if (pick < 80) begin
            // digits at or past the end of the kept bytes
            msg_buf.push_back($urandom_range(1) ? CH_M : CH_W);
            repeat ($urandom_range(27, 31)) push_blank();
            repeat (3) msg_buf.push_back(digit_char($urandom_range(9)));
            msg_buf.push_back(CH_CR);
        end else begin
            repeat ($urandom_range(1, 6)) msg_buf.push_back(random_byte());
        end
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) msg_buf.push_back(random_byte());
        // overlong message, tail dropped by the parser
        if ($urandom_range(99) < 8) begin
            pick = $urandom_range(33, 40);
            while (msg_buf.size() < pick)
                msg_buf.push_back(random_byte());
        end
    endtask

    task automatic test_directed();
        msg_buf = '{CH_S, CH_CR};
        send_message(random_az(), random_el());
        msg_buf = '{CH_C, CH_CR};
        send_message(13'd8191, 11'd0);
        msg_buf = '{CH_B, CH_CR};
        send_message(13'd0, 11'd2047);
        msg_buf = '{CH_C, CH_2, CH_CR};
        send_message(13'd4500, 11'd1800);
        msg_buf = '{CH_M, CH_9, CH_9, CH_9, CH_CR};
        send_message(random_az(), random_el());
        // sign ends the azimuth with no digits, elevation is skipped
        msg_buf = '{CH_W, CH_MINUS, digit_char(1), CH_2, CH_SPACE, digit_char(3),
                    digit_char(4), digit_char(5), CH_CR};
        send_message(random_az(), random_el());
        msg_buf = '{8'hff};
        send_message(13'd0, 11'd0);
    endtask

    task automatic test_random_messages(input int beat_goal);
        while (beats_sent < beat_goal) begin
            build_random_message();
            send_message(random_az(), random_el());
        end
    endtask

    task automatic test_back_to_back(input int beat_goal);
        idle_on = 1'b0;
        test_random_messages(beat_goal);
        idle_on = 1'b1;
    endtask

    // long output hold-off with queries streaming in fills the command queue
    task automatic test_output_stall();
        hold_request = 400;
        repeat (8) begin
            msg_buf = '{CH_C, CH_2, CH_CR};
            send_message(random_az(), random_el());
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (idle_on) begin
            res_if.ready <= ($urandom_range(99) >= 10);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (parsed_results.size() == 0) begin
                $error("result beat with nothing pending: out_kind %0d", res_if.out_kind);
                mismatch_count++;
            end else begin
                want = parsed_results.pop_front();
                if (res_if.out_kind !== want.kind) begin
                    $error("out_kind: expected %0d, got %0d", want.kind, res_if.out_kind);
                    mismatch_count++;
                end
                if (res_if.reply_byte !== want.ch) begin
                    $error("reply_byte: expected %h, got %h", want.ch, res_if.reply_byte);
                    mismatch_count++;
                end
                if (res_if.target_az_ddeg !== want.az) begin
                    $error("target_az_ddeg: expected %0d, got %0d",
                           want.az, res_if.target_az_ddeg);
                    mismatch_count++;
                end
                if (res_if.target_el_ddeg !== want.el) begin
                    $error("target_el_ddeg: expected %0d, got %0d",
                           want.el, res_if.target_el_ddeg);
                    mismatch_count++;
                end
                if (res_if.out_last !== want.last) begin
                    $error("out_last: expected %0d, got %0d", want.last, res_if.out_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.rx_byte         = '0;
        cmd_if.end_of_message  = 1'b0;
        cmd_if.current_az_ddeg = '0;
        cmd_if.current_el_ddeg = '0;
        res_if.ready           = 1'b0;
        kept_bytes             = 0;
        beats_sent             = 0;
        mismatch_count         = 0;
        idle_on                = 1'b1;
        hold_request           = 0;
        hold_left              = 0;
        quiet_cycles           = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_messages(130);
        wait_drained();
        test_back_to_back(170);
        test_output_stall();
        test_random_messages(260);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && parsed_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
